[rtl/core/csv_field_splitter_macros.svh]
// ----------------------------------------------------------------------------
// CSV field splitter assertion macros
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_SPLITTER_MACROS_SVH
`define CSV_FIELD_SPLITTER_MACROS_SVH

`ifndef SYNTHESIS
`define CSVFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CSVFS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define CSVFS_ASSERT(lbl, prop, msg)
`define CSVFS_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

[rtl/core/csvfs_pkg.sv]
// ----------------------------------------------------------------------------
// CSV field splitter package
// Byte codes, result item layout and the push bundle between core and queue.
// ----------------------------------------------------------------------------
package csvfs_pkg;

  localparam int CHAR_W  = 8;
  localparam int FNUM_W  = 11;
  localparam int START_W = 10;
  localparam int LEN_W   = 11;

  localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;

  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  typedef struct packed {
    logic               line_overflow;
    logic               row_last;
    logic [LEN_W-1:0]   content_length;
    logic [START_W-1:0] content_start;
    logic [FNUM_W-1:0]  field_number;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
  endfunction

endpackage

[rtl/core/csvfs_core.sv]
`include "csv_field_splitter_macros.svh"
// ----------------------------------------------------------------------------
// CSV field splitter core
// Input register, field tracking and result forming; a byte a cycle if room_i.
// ----------------------------------------------------------------------------
module csvfs_core #(
  parameter int LINE_MAX = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [csvfs_pkg::CHAR_W-1:0] s_char_i,
  input  logic                       s_last_i,
  input  logic                       room_i,
  output csvfs_pkg::push_t           push_o
);
  import csvfs_pkg::*;

  localparam int PW = $clog2(LINE_MAX + 1);
  localparam int OW = $clog2(LINE_MAX);
  localparam int XW = (PW > FNUM_W) ? PW : FNUM_W;

  typedef struct packed {
    logic [PW-1:0] field_begin;
    logic          opens_with_quote;
    logic          solid_seen;
    logic          solid_before;
    logic          tail_quote;
    logic          has_byte;
    logic [OW-1:0] first_solid;
    logic [OW-1:0] last_solid;
    logic [OW-1:0] last_solid_before;
  } fld_t;

  logic              in_valid_q, in_valid_d;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;
  logic              fire;

  logic [PW-1:0] byte_position_q, byte_position_d;
  logic [PW-1:0] field_counter_q, field_counter_d;
  logic          quoted_q, quoted_d;
  logic          overflow_q, overflow_d;
  fld_t          fld_q, fld_d, nf, src;

  logic [OW-1:0] off;
  logic [PW-1:0] off_inc;
  logic [PW-1:0] cnt_inc;
  logic          comma_split;
  logic          has;
  logic [OW-1:0] z;
  logic [OW-1:0] start0, start1;
  logic [PW-1:0] len0;
  logic [XW-1:0] fnum0_x, fnum1_x, start0_x, start1_x, len0_x;

  assign s_ready_o = !in_valid_q || room_i;
  assign fire      = in_valid_q && room_i;

  always_comb begin
    in_valid_d = in_valid_q;
    if (fire) begin
      in_valid_d = 1'b0;
    end
    if (s_valid_i && s_ready_o) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      char_q <= s_char_i;
      last_q <= s_last_i;
    end
  end

  // position of this byte, saturated at the last offset
  always_comb begin
    overflow_d = overflow_q;
    if (byte_position_q >= PW'(LINE_MAX)) begin
      overflow_d = 1'b1;
      off        = OW'(LINE_MAX - 1);
    end else begin
      off        = OW'(byte_position_q);
    end
    byte_position_d = (byte_position_q < PW'(LINE_MAX)) ? byte_position_q + PW'(1)
                                                         : PW'(LINE_MAX);
    cnt_inc = (field_counter_q < PW'(LINE_MAX)) ? field_counter_q + PW'(1)
                                                 : PW'(LINE_MAX);
    off_inc     = PW'(off) + PW'(1);
    comma_split = (char_q == CHAR_COMMA) && !quoted_q;
  end

  // field state after taking this byte in
  always_comb begin
    nf          = fld_q;
    nf.has_byte = 1'b1;
    if (!fld_q.has_byte && (char_q == CHAR_QUOTE)) begin
      nf.opens_with_quote = 1'b1;
      nf.tail_quote       = 1'b0;
    end else begin
      nf.solid_before      = fld_q.solid_seen;
      nf.last_solid_before = fld_q.last_solid;
      nf.tail_quote        = (char_q == CHAR_QUOTE);
      if (!is_blank(char_q)) begin
        if (!fld_q.solid_seen) begin
          nf.first_solid = off;
        end
        nf.last_solid = off;
        nf.solid_seen = 1'b1;
      end
    end
  end

  // result forming
  always_comb begin
    src = comma_split ? fld_q : nf;
    if (src.opens_with_quote && src.tail_quote) begin
      has = src.solid_before;
      z   = src.last_solid_before;
    end else begin
      has = src.solid_seen;
      z   = src.last_solid;
    end
    if (has && (z >= src.first_solid)) begin
      start0 = src.first_solid;
      len0   = PW'(z) - PW'(src.first_solid) + PW'(1);
    end else begin
      start0 = (src.field_begin < PW'(LINE_MAX)) ? OW'(src.field_begin)
                                                  : OW'(LINE_MAX - 1);
      len0   = '0;
    end
    start1 = (off_inc < PW'(LINE_MAX)) ? OW'(off_inc) : OW'(LINE_MAX - 1);

    fnum0_x  = XW'(field_counter_q);
    fnum1_x  = XW'(cnt_inc);
    start0_x = XW'(start0);
    start1_x = XW'(start1);
    len0_x   = XW'(len0);

    push_o.first.field_number   = fnum0_x[FNUM_W-1:0];
    push_o.first.content_start  = start0_x[START_W-1:0];
    push_o.first.content_length = len0_x[LEN_W-1:0];
    push_o.first.row_last       = !comma_split;
    push_o.first.line_overflow  = overflow_d;

    push_o.second.field_number   = fnum1_x[FNUM_W-1:0];
    push_o.second.content_start  = start1_x[START_W-1:0];
    push_o.second.content_length = '0;
    push_o.second.row_last       = 1'b1;
    push_o.second.line_overflow  = overflow_d;

    if (!fire) begin
      push_o.count = PUSH_NONE;
    end else if (comma_split) begin
      push_o.count = last_q ? PUSH_TWO : PUSH_ONE;
    end else begin
      push_o.count = last_q ? PUSH_ONE : PUSH_NONE;
    end
  end

  // state update; a line end returns the line state to reset
  always_comb begin
    field_counter_d = field_counter_q;
    quoted_d        = quoted_q;
    fld_d           = nf;
    if (comma_split) begin
      field_counter_d   = cnt_inc;
      fld_d             = '0;
      fld_d.field_begin = off_inc;
    end else if (char_q == CHAR_QUOTE) begin
      quoted_d = !quoted_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q      <= 1'b0;
      byte_position_q <= '0;
      field_counter_q <= '0;
      quoted_q        <= 1'b0;
      overflow_q      <= 1'b0;
      fld_q           <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (fire) begin
        if (last_q) begin
          byte_position_q <= '0;
          field_counter_q <= '0;
          quoted_q        <= 1'b0;
          overflow_q      <= 1'b0;
          fld_q           <= '0;
        end else begin
          byte_position_q <= byte_position_d;
          field_counter_q <= field_counter_d;
          quoted_q        <= quoted_d;
          overflow_q      <= overflow_d;
          fld_q           <= fld_d;
        end
      end
    end
  end

  `CSVFS_ASSERT_NEXT(a_line_end_clears, fire && last_q,
    (byte_position_q == '0) && (field_counter_q == '0) && !quoted_q && !overflow_q,
    "line end did not clear the line state")
  `CSVFS_ASSERT(a_two_only_on_comma, (push_o.count != PUSH_TWO) ||
    (last_q && (char_q == CHAR_COMMA) && !quoted_q), "two results without a final comma")
  `CSVFS_ASSERT(a_overflow_saturated, !overflow_q || (byte_position_q == PW'(LINE_MAX)),
    "overflow flag set below the line limit")

endmodule

[rtl/core/csv_field_splitter.sv]
`include "csv_field_splitter_macros.svh"
// ----------------------------------------------------------------------------
// CSV field splitter
// Splits a byte stream of text lines into comma-separated field descriptors.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                  | tlast     | tuser
//  s_axis   | in  | char_in[7:0]                           | line_last | -
//  m_axis   | out | field_number, content_start, length    | row_last  | line_overflow
//
// One byte a cycle while the output queue has room; a byte passes the input
// register and then enters the output queue. A comma that ends a line yields
// two items. The three-entry output queue takes a byte's results while it holds
// at most one item, so a stalled m_axis stops s_axis once two items wait and a
// byte holds the input register. Reset clears line state and empties the queue.
// ----------------------------------------------------------------------------
module csv_field_splitter #(
  parameter int LINE_MAX = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [10:0] field_number, [20:11] content_start,
                                     // [31:21] content_length
  output logic        m_axis_tlast,
  output logic        m_axis_tuser   // [0] line_overflow
);
  import csvfs_pkg::*;

  localparam int DEPTH = 3;

  push_t      push;
  logic       room;
  logic       pop;
  logic [1:0] count_q, count_d;
  logic [1:0] base;
  res_t       ent_q [DEPTH];
  res_t       ent_d [DEPTH];

  csvfs_core #(
    .LINE_MAX (LINE_MAX)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_char_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .room_i    (room),
    .push_o    (push)
  );

  assign room = (count_q <= 2'd1);
  assign pop  = (count_q != 2'd0) && m_axis_tready;
  assign base = count_q - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && (i < DEPTH - 1)) begin
        ent_d[i] = ent_q[i+1];
      end else begin
        ent_d[i] = ent_q[i];
      end
      if ((push.count != PUSH_NONE) && (base == 2'(i))) begin
        ent_d[i] = push.first;
      end
      if ((push.count == PUSH_TWO) && ((base + 2'd1) == 2'(i))) begin
        ent_d[i] = push.second;
      end
    end
    count_d = base + push.count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign m_axis_tvalid = (count_q != 2'd0);
  assign m_axis_tdata  = {ent_q[0].content_length, ent_q[0].content_start,
                          ent_q[0].field_number};
  assign m_axis_tlast  = ent_q[0].row_last;
  assign m_axis_tuser  = ent_q[0].line_overflow;

  `CSVFS_ASSERT(a_push_fits, (push.count == PUSH_NONE) || (count_q <= 2'd1),
    "results pushed into a queue without room")
  `CSVFS_ASSERT_NEXT(a_hold_while_stalled, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "output item changed while stalled")
  `CSVFS_ASSERT_NEXT(a_drain_empties, pop && (push.count == PUSH_NONE) && (count_q == 2'd1),
    count_q == 2'd0, "queue did not empty after the last item left")

endmodule
